// ----- hw/rtl/qjtg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register map and reset constants of the quintic joint trajectory generator.
package qjtg_pkg;

    localparam int ANGLE_W    = 19;
    localparam int TIME_W     = 26;
    localparam int TICK_W     = 16;
    localparam int MAX_JOINTS = 12;
    localparam int APB_DW     = 32;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic [TIME_W-1:0]         t_time;

    // Register map: duration first, then one goal register per joint
    localparam int REG_DURATION  = 0;
    localparam int REG_GOAL_BASE = 1;

    localparam t_time DUR_RESET = 26'd5000000;

    localparam t_angle GOAL_RESET [MAX_JOINTS] = '{
        19'sd32768, -19'sd49709, 19'sd0, -19'sd88867, 19'sd0, 19'sd102957,
        19'sd51446, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0
    };

endpackage

// ----- hw/rtl/quintic_joint_trajectory_generator.sv -----
`timescale 1ns / 1ps
// Quintic smoothstep point-to-point trajectory generator for a group of joints.
//
// One request on the slave stream is one control tick: tick time in microseconds plus the
// measured angle of every joint. One result on the master stream follows each request:
// the commanded angle of every joint, with move_done on tuser once the move is over.
// The first tick after reset latches the measured angles as the start pose.
// Duration and goal angles sit in APB registers (duration at 0x0, goal i at 4*(i+1)).
//
// Steps: a tick inside the move runs a bit-serial divider for the normalized time, four
// shift-add multiply passes (s^2, s^3, smoothstep, then all joint lanes together) with a
// fix-up step after each of the scalar passes, then loads the result register. The next
// request is taken only once the result has been loaded into the result register, so one
// tick is in flight at a time. A tick at or past the end of the move skips the arithmetic
// and goes straight to the output step.
// The result register holds a finished result while the receiver stalls; a new request
// is still taken, and only the final hand-over waits for the result register to drain.
// Reset (synchronous, active low) clears elapsed time, the start latch and the output,
// and loads duration and goals with their reset values.
module quintic_joint_trajectory_generator
    import qjtg_pkg::*;
#(
    parameter int JOINT_COUNT = 7,
    parameter int FRAC_BITS   = 16,
    localparam int IN_W  = ((TICK_W + ANGLE_W * JOINT_COUNT + 7) / 8) * 8,
    localparam int OUT_W = ((ANGLE_W * JOINT_COUNT + 7) / 8) * 8,
    localparam int AW    = $clog2(4 * (JOINT_COUNT + 1))
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tick_us, meas_angle_0 .. meas_angle_N-1, zero padding
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // cmd_angle_0 .. cmd_angle_N-1, zero padding
    output logic [OUT_W-1:0]  o_m_axis_tdata,
    // move_done
    output logic              o_m_axis_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AW-1:0]     paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int F    = FRAC_BITS;
    localparam int IW   = AW - 2;
    localparam int SW   = F + 1;            // Q1.F values up to one
    localparam int PW   = F + 4;            // polynomial, up to 10*ONE
    localparam int PRW  = PW + SW;          // scalar product
    localparam int PLW  = F + 6;            // signed polynomial sum
    localparam int DW   = ANGLE_W + 1;      // goal - start
    localparam int LW   = F + ANGLE_W;      // kept low part of a lane product
    localparam int CW   = $clog2(F + 1);

    localparam logic [PRW-1:0]   HALF_P  = PRW'(1) << (F - 1);
    localparam logic [LW-1:0]    HALF_L  = LW'(1) << (F - 1);
    localparam logic [PRW-F-1:0] ONE_Q   = (PRW - F)'(1) << F;
    localparam logic [PLW-1:0]   TEN_ONE = PLW'(10) << F;
    localparam logic [CW-1:0]    LAST_M  = CW'(F);
    localparam logic [CW-1:0]    LAST_D  = CW'(F - 1);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_DIV       = 10'b00_0000_0010,
        S_SQ        = 10'b00_0000_0100,
        S_SQ_FIX    = 10'b00_0000_1000,
        S_CUBE      = 10'b00_0001_0000,
        S_CUBE_FIX  = 10'b00_0010_0000,
        S_BLEND     = 10'b00_0100_0000,
        S_BLEND_FIX = 10'b00_1000_0000,
        S_JNT       = 10'b01_0000_0000,
        S_OUT       = 10'b10_0000_0000
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    t_time           r_dur;
    t_angle          r_goal [JOINT_COUNT];
    t_time           r_elapsed;
    logic            r_latched;
    logic            r_out_valid;

    t_angle          r_start [JOINT_COUNT];
    logic            r_done;
    t_time           r_rem;
    logic [SW-1:0]   r_s;
    logic [SW-1:0]   r_s2;
    logic [F+2:0]    r_t6;
    logic [PW-1:0]   r_poly;
    logic [SW-1:0]   r_mb;
    logic [PW-1:0]   r_acc_hi;
    logic [SW-1:0]   r_acc_lo;
    logic signed [DW-1:0] r_diff    [JOINT_COUNT];
    logic signed [DW-1:0] r_lane_hi [JOINT_COUNT];
    logic [SW-1:0]        r_lane_lo [JOINT_COUNT];
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_done;

    logic            in_acc;
    logic            out_load;
    logic            cfg_wr;
    logic [IW-1:0]   cfg_idx;
    logic [TICK_W-1:0] tick;
    logic [TIME_W:0] e_sum;
    t_time           n_elapsed;
    logic            n_done;
    logic [TIME_W:0] rem2;
    logic [TIME_W:0] rem_sub;
    logic            qbit;
    t_time           n_rem;
    logic [PW-1:0]   mul_a;
    logic [PW:0]     m_sum;
    logic [PW-1:0]   n_acc_hi;
    logic [SW-1:0]   n_acc_lo;
    logic [PRW-1:0]  prod;
    logic [PRW-1:0]  rnd;
    logic [PRW-F-1:0] rnd_q;
    logic [SW-1:0]   smooth;
    logic [PRW-1:0]  p6;
    logic [PRW-1:0]  r6;
    logic [PLW-1:0]  pol;
    logic [PW-1:0]   n_poly;
    logic signed [DW-1:0] ladd      [JOINT_COUNT];
    logic signed [DW:0]   lsum      [JOINT_COUNT];
    logic signed [DW-1:0] n_lane_hi [JOINT_COUNT];
    logic [SW-1:0]        n_lane_lo [JOINT_COUNT];
    logic [DW+SW-1:0]     lprod     [JOINT_COUNT];
    logic [LW-1:0]        lrnd      [JOINT_COUNT];
    t_angle               cmd       [JOINT_COUNT];
    logic [OUT_W-1:0]     n_out_data;

    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_done;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[AW-1:2];

    always_comb begin
        prdata = '0;
        if (cfg_idx == IW'(REG_DURATION)) begin
            prdata = {{(APB_DW-TIME_W){1'b0}}, r_dur};
        end
        for (int j = 0; j < JOINT_COUNT; j++) begin
            if (cfg_idx == IW'(REG_GOAL_BASE + j)) begin
                prdata = {{(APB_DW-ANGLE_W){r_goal[j][ANGLE_W-1]}}, r_goal[j]};
            end
        end
    end

    // Running time, clamped to the duration
    always_comb begin
        tick      = i_s_axis_tdata[TICK_W-1:0];
        e_sum     = {1'b0, r_elapsed} + {{(TIME_W+1-TICK_W){1'b0}}, tick};
        n_elapsed = (e_sum > {1'b0, r_dur}) ? r_dur : e_sum[TIME_W-1:0];
        n_done    = (n_elapsed >= r_dur);
    end

    // Restoring divider, one quotient bit per cycle
    always_comb begin
        rem2    = {r_rem, 1'b0};
        rem_sub = rem2 - {1'b0, r_dur};
        qbit    = (rem2 >= {1'b0, r_dur});
        n_rem   = qbit ? rem_sub[TIME_W-1:0] : rem2[TIME_W-1:0];
    end

    // Shared shift-add multiplier for the scalar chain, LSB of the multiplier first
    always_comb begin
        case (r_state)
            S_CUBE:  mul_a = {{(PW-SW){1'b0}}, r_s2};
            S_BLEND: mul_a = r_poly;
            default: mul_a = {{(PW-SW){1'b0}}, r_s};
        endcase
        m_sum    = {1'b0, r_acc_hi} + {1'b0, (r_mb[0] ? mul_a : {PW{1'b0}})};
        n_acc_hi = m_sum[PW:1];
        n_acc_lo = {m_sum[0], r_acc_lo[SW-1:1]};
    end

    // Rounding and polynomial fix-ups between multiply passes
    always_comb begin
        prod   = {r_acc_hi, r_acc_lo};
        rnd    = prod + HALF_P;
        rnd_q  = rnd[PRW-1:F];
        smooth = (rnd_q > ONE_Q) ? ONE_Q[SW-1:0] : rnd_q[SW-1:0];
        p6     = {prod[PRW-3:0], 2'b00} + {prod[PRW-2:0], 1'b0};
        r6     = p6 + HALF_P;
        pol    = TEN_ONE - {1'b0, r_s, 4'b0000} + {5'b00000, r_s}
                 + {3'b000, r_t6};
        n_poly = pol[PLW-1] ? '0 : pol[PW-1:0];
    end

    // Joint lanes: signed diff times smooth, plus output rounding
    always_comb begin
        n_out_data = '0;
        for (int j = 0; j < JOINT_COUNT; j++) begin
            ladd[j]      = r_mb[0] ? r_diff[j] : '0;
            lsum[j]      = {r_lane_hi[j][DW-1], r_lane_hi[j]} + {ladd[j][DW-1], ladd[j]};
            n_lane_hi[j] = lsum[j][DW:1];
            n_lane_lo[j] = {lsum[j][0], r_lane_lo[j][SW-1:1]};
            lprod[j]     = {r_lane_hi[j], r_lane_lo[j]};
            lrnd[j]      = lprod[j][LW-1:0] + HALF_L;
            cmd[j]       = r_done ? r_goal[j] : (r_start[j] + lrnd[j][LW-1:F]);
            n_out_data[j*ANGLE_W +: ANGLE_W] = cmd[j];
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_dur       <= DUR_RESET;
            r_elapsed   <= '0;
            r_latched   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < JOINT_COUNT; j++) begin
                r_goal[j] <= GOAL_RESET[j];
            end
        end else begin
            if (cfg_wr && cfg_idx == IW'(REG_DURATION)) begin
                r_dur <= pwdata[TIME_W-1:0];
            end
            for (int j = 0; j < JOINT_COUNT; j++) begin
                if (cfg_wr && cfg_idx == IW'(REG_GOAL_BASE + j)) begin
                    r_goal[j] <= pwdata[ANGLE_W-1:0];
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_latched <= 1'b1;
                        r_elapsed <= n_elapsed;
                        r_cnt     <= '0;
                        // finished move: goal pose, no arithmetic
                        r_state   <= n_done ? S_OUT : S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == LAST_D) begin
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQ, S_CUBE, S_BLEND, S_JNT: begin
                    if (r_cnt == LAST_M) begin
                        r_cnt <= '0;
                        case (r_state)
                            S_SQ:    r_state <= S_SQ_FIX;
                            S_CUBE:  r_state <= S_CUBE_FIX;
                            S_BLEND: r_state <= S_BLEND_FIX;
                            default: r_state <= S_OUT;
                        endcase
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQ_FIX:    r_state <= S_CUBE;
                S_CUBE_FIX:  r_state <= S_BLEND;
                S_BLEND_FIX: r_state <= S_JNT;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_done <= n_done;
                    r_rem  <= n_elapsed;
                    r_s    <= '0;
                    if (!r_latched) begin
                        for (int j = 0; j < JOINT_COUNT; j++) begin
                            r_start[j] <= i_s_axis_tdata[TICK_W + j*ANGLE_W +: ANGLE_W];
                        end
                    end
                end
            end
            S_DIV: begin
                r_rem    <= n_rem;
                r_s      <= {r_s[SW-2:0], qbit};
                r_mb     <= {r_s[SW-2:0], qbit};
                r_acc_hi <= '0;
                r_acc_lo <= '0;
            end
            S_SQ, S_CUBE, S_BLEND: begin
                r_acc_hi <= n_acc_hi;
                r_acc_lo <= n_acc_lo;
                r_mb     <= r_mb >> 1;
            end
            S_SQ_FIX: begin
                r_s2     <= rnd_q[SW-1:0];
                r_t6     <= r6[2*F+2:F];
                r_mb     <= r_s;
                r_acc_hi <= '0;
                r_acc_lo <= '0;
            end
            S_CUBE_FIX: begin
                r_poly   <= n_poly;
                r_mb     <= rnd_q[SW-1:0];
                r_acc_hi <= '0;
                r_acc_lo <= '0;
            end
            S_BLEND_FIX: begin
                r_mb <= smooth;
                for (int j = 0; j < JOINT_COUNT; j++) begin
                    r_diff[j]    <= {r_goal[j][ANGLE_W-1], r_goal[j]}
                                    - {r_start[j][ANGLE_W-1], r_start[j]};
                    r_lane_hi[j] <= '0;
                    r_lane_lo[j] <= '0;
                end
            end
            S_JNT: begin
                r_mb <= r_mb >> 1;
                for (int j = 0; j < JOINT_COUNT; j++) begin
                    r_lane_hi[j] <= n_lane_hi[j];
                    r_lane_lo[j] <= n_lane_lo[j];
                end
            end
            S_OUT: begin
                if (out_load) begin
                    r_out_data <= n_out_data;
                    r_out_done <= r_done;
                end
            end
            default: begin
                r_mb <= r_mb;
            end
        endcase
    end

endmodule

// ----- hw/rtl/qjtg_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the quintic joint trajectory generator, bound to the top level.
module qjtg_checker
    import qjtg_pkg::*;
#(
    parameter int JOINT_COUNT = 7,
    localparam int OUT_W = ((ANGLE_W * JOINT_COUNT + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // one tick in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while a tick is in flight");

endmodule

bind quintic_joint_trajectory_generator qjtg_checker #(
    .JOINT_COUNT(JOINT_COUNT)
) u_qjtg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
